// File: hdl/ffba_pkg.sv
// Shared constants, codes and payload types for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS     = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 32;
    localparam int HEADER_BYTES = 32;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_ZERO      = 3'd1,
        STATUS_EXHAUSTED = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_UNMATCHED = 3'd4
    } status_t;

    typedef enum logic {
        CFG_HEAP_START = 1'b0,
        CFG_HEAP_END   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    typedef struct packed {
        logic launch;
        logic rsp_take;
    } eng_cmd_t;

    typedef struct packed {
        logic idle;
        logic rsp_valid;
    } eng_sts_t;

endpackage

`default_nettype wire

// File: hdl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: ports, configuration and result register.
//
// One request is handled at a time. An allocate or free walks the block table in creation
// order through the single read port of the table memory, one entry per cycle, and stops
// at the first matching entry or after the last of at most MAX_BLOCKS entries; a zero-size
// allocate skips the walk. The result sits in an output register, so the next request is
// taken while the previous result waits for its transfer.
`default_nettype none

module first_fit_block_allocator import ffba_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wen,
    input  wire cfg_idx_t          cfg_index,
    input  wire logic [ADDR_W-1:0] cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire req_t              s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rsp_t                   m_data
);

    logic [ADDR_W-1:0] heap_start_reg, heap_start_next;
    logic [ADDR_W-1:0] heap_end_reg, heap_end_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    eng_cmd_t          cmd;
    eng_sts_t          sts;
    rsp_t              eng_rsp;

    ffba_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req        (s_data),
        .heap_start (heap_start_reg),
        .heap_end   (heap_end_reg),
        .sts        (sts),
        .rsp        (eng_rsp)
    );

    always_comb begin
        s_ready      = sts.idle;
        cmd.launch   = s_valid && sts.idle;
        cmd.rsp_take = sts.rsp_valid && (!m_valid_reg || m_ready);
        m_valid      = m_valid_reg;
        m_data       = m_data_reg;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.rsp_take) begin
            m_valid_next = 1'b1;
            m_data_next  = eng_rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        heap_start_next = heap_start_reg;
        heap_end_next   = heap_end_reg;
        if (cfg_wen) begin
            case (cfg_index)
                CFG_HEAP_START: heap_start_next = cfg_wdata;
                CFG_HEAP_END:   heap_end_next   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg <= '0;
            heap_end_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            heap_start_reg <= heap_start_next;
            heap_end_reg   <= heap_end_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// File: hdl/ffba_engine.sv
// Block table memory, scan sequencer and append/reuse/free update logic.
`default_nettype none

module ffba_engine import ffba_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire eng_cmd_t          cmd,
    input  wire req_t              req,
    input  wire logic [ADDR_W-1:0] heap_start,
    input  wire logic [ADDR_W-1:0] heap_end,
    output eng_sts_t               sts,
    output rsp_t                   rsp
);

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] iss_reg, iss_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_BITS-1:0] chk_idx_reg, chk_idx_next;
    op_t                 op_reg, op_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W:0]     base_hdr_reg, base_hdr_next;
    logic [ADDR_W-1:0]   last_end_reg, last_end_next;
    rsp_t                rsp_reg, rsp_next;

    entry_t              table_mem [MAX_BLOCKS];
    entry_t              rd_data_reg;
    entry_t              ent;
    entry_t              wr_data;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_idx;
    logic                rd_en;

    logic                hit;
    logic                last;
    logic                zero_req;
    logic [ADDR_W+1:0]   need;
    logic                exhausted;
    logic                full;

    assign ent       = rd_data_reg;
    assign rd_en     = (state_reg == ST_SCAN) && (iss_reg < count_reg);
    assign last      = (iss_reg == count_reg);
    assign zero_req  = (req.operation == OP_ALLOC) && (req.request_size == '0);
    assign need      = {1'b0, base_hdr_reg} + {2'b0, size_reg};
    assign exhausted = need > {2'b0, heap_end};
    assign full      = (count_reg == CNT_BITS'(MAX_BLOCKS));

    always_comb begin
        if (op_reg == OP_ALLOC) begin
            hit = chk_valid_reg && ent.free && (ent.size >= size_reg);
        end else begin
            hit = chk_valid_reg && (ent.start == addr_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.launch) begin
                    state_next = zero_req ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.rsp_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        iss_next       = iss_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        base_hdr_next  = base_hdr_reg;
        last_end_next  = last_end_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_idx         = chk_idx_reg;
        wr_data        = ent;

        case (state_reg)
            ST_IDLE: begin
                if (cmd.launch) begin
                    op_next   = req.operation;
                    size_next = req.request_size;
                    addr_next = req.release_address;
                    iss_next  = '0;
                    if (count_reg == '0) begin
                        base_hdr_next = {1'b0, heap_start} + (ADDR_W+1)'(HEADER_BYTES);
                    end else begin
                        base_hdr_next = {1'b0, last_end_reg} + (ADDR_W+1)'(HEADER_BYTES);
                    end
                    rsp_next.block_address = '0;
                    rsp_next.status        = STATUS_ZERO;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    iss_next       = iss_reg + CNT_BITS'(1);
                    chk_idx_next   = iss_reg[IDX_BITS-1:0];
                    chk_valid_next = 1'b1;
                end
                if (hit) begin
                    wr_en        = 1'b1;
                    wr_idx       = chk_idx_reg;
                    wr_data      = ent;
                    wr_data.free = (op_reg == OP_FREE);
                    rsp_next.block_address = (op_reg == OP_ALLOC) ? ent.start : '0;
                    rsp_next.status        = STATUS_OK;
                end else if (last) begin
                    rsp_next.block_address = '0;
                    if (op_reg == OP_FREE) begin
                        rsp_next.status = STATUS_UNMATCHED;
                    end else if (exhausted) begin
                        rsp_next.status = STATUS_EXHAUSTED;
                    end else if (full) begin
                        rsp_next.status = STATUS_FULL;
                    end else begin
                        wr_en         = 1'b1;
                        wr_idx        = count_reg[IDX_BITS-1:0];
                        wr_data.start = base_hdr_reg[ADDR_W-1:0];
                        wr_data.size  = size_reg;
                        wr_data.free  = 1'b0;
                        count_next    = count_reg + CNT_BITS'(1);
                        last_end_next = need[ADDR_W-1:0];
                        rsp_next.block_address = base_hdr_reg[ADDR_W-1:0];
                        rsp_next.status        = STATUS_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sts.idle      = (state_reg == ST_IDLE);
        sts.rsp_valid = (state_reg == ST_DONE);
        rsp           = rsp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg      <= iss_next;
        chk_idx_reg  <= chk_idx_next;
        op_reg       <= op_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        base_hdr_reg <= base_hdr_next;
        last_end_reg <= last_end_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[iss_reg[IDX_BITS-1:0]];
        end
    end

endmodule

`default_nettype wire

// File: tb/first_fit_block_allocator_tb.sv
// Self-checking testbench: first-fit allocator against a block-table predictor.
`default_nettype none

module first_fit_block_allocator_tb import ffba_pkg::*; ();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 80;
    localparam int HOLD_CYCLES = 400;

    class heap_ledger;
        logic [ADDR_W-1:0] heap_base;
        logic [ADDR_W-1:0] heap_limit;
        logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
        logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
        bit                blk_free  [MAX_BLOCKS];
        int                blk_count;
        rsp_t              pending_grants [$];
        int                errors;

        function new();
            heap_base  = '0;
            heap_limit = '0;
            blk_count  = 0;
            errors     = 0;
        endfunction

        function rsp_t grant(input logic [SIZE_W-1:0] size);
            rsp_t              g;
            logic [ADDR_W-1:0] base;
            logic [ADDR_W+1:0] top;
            logic [ADDR_W+1:0] hdr;
            bit                hit;
            g.block_address = '0;
            g.status        = STATUS_OK;
            hit             = 1'b0;
            hdr             = (ADDR_W+2)'(HEADER_BYTES);
            if (size == '0) begin
                g.status = STATUS_ZERO;
                return g;
            end
            for (int i = 0; i < blk_count && !hit; i++) begin
                if (blk_free[i] && blk_size[i] >= size) begin
                    blk_free[i]     = 1'b0;
                    g.block_address = blk_start[i];
                    hit             = 1'b1;
                end
            end
            if (hit)
                return g;
            base = (blk_count == 0) ? heap_base
                                    : blk_start[blk_count - 1] + blk_size[blk_count - 1];
            top = {2'b00, base} + {2'b00, size} + hdr;
            if (top > {2'b00, heap_limit}) begin
                g.status = STATUS_EXHAUSTED;
            end else if (blk_count >= MAX_BLOCKS) begin
                g.status = STATUS_FULL;
            end else begin
                blk_start[blk_count] = base + ADDR_W'(HEADER_BYTES);
                blk_size[blk_count]  = size;
                blk_free[blk_count]  = 1'b0;
                g.block_address      = blk_start[blk_count];
                blk_count++;
            end
            return g;
        endfunction

        function void note_request(input req_t item);
            rsp_t g;
            bit   hit;
            hit = 1'b0;
            if (item.operation == OP_FREE) begin
                g.block_address = '0;
                g.status        = STATUS_UNMATCHED;
                for (int i = 0; i < blk_count && !hit; i++) begin
                    if (blk_start[i] == item.release_address) begin
                        blk_free[i] = 1'b1;
                        g.status    = STATUS_OK;
                        hit         = 1'b1;
                    end
                end
            end else begin
                g = grant(item.request_size);
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(input rsp_t got);
            rsp_t want;
            if (pending_grants.size() == 0) begin
                $error("unexpected result: block_address %h, status %0d",
                       got.block_address, got.status);
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            if (got.block_address !== want.block_address) begin
                $error("block_address: expected %h, got %h",
                       want.block_address, got.block_address);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    cfg_idx_t          cfg_index = CFG_HEAP_START;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    req_t              s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    rsp_t              m_data;

    heap_ledger ledger;
    bit         sender_quiet = 1'b0;
    int         cycle_count  = 0;

    first_fit_block_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_block_allocator: mismatch");
            $finish;
        end
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    function automatic req_t random_request();
        req_t item;
        int   pick;
        int   slot;
        item.operation       = OP_ALLOC;
        item.request_size    = $urandom();
        item.release_address = $urandom();
        pick = $urandom_range(0, 99);
        slot = (ledger.blk_count > 0) ? $urandom_range(0, ledger.blk_count - 1) : 0;
        if (pick < 25) begin
            item.request_size = $urandom_range(1, 256);
        end else if (pick < 40) begin
            item.request_size = (ledger.blk_count > 0) ?
                                $urandom_range(1, ledger.blk_size[slot]) : 1;
        end else if (pick < 45) begin
            item.request_size = $urandom_range(257, 4096);
        end else if (pick < 50) begin
            item.request_size = '0;
        end else if (pick < 55) begin
            item.request_size = {8'($urandom_range(1, 255)), 24'($urandom())};
        end else begin
            item.operation = OP_FREE;
            if (pick < 85 && ledger.blk_count > 0)
                item.release_address = ledger.blk_start[slot];
            else if (pick < 93 && ledger.blk_count > 0)
                item.release_address = ledger.blk_start[slot] ^ (32'd1 << $urandom_range(0, 5));
        end
        return item;
    endfunction

    task automatic send_request(input req_t item);
        int gap;
        gap = (sender_quiet || $urandom_range(0, 99) < 50) ? 0 : gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        ledger.note_request(item);
    endtask

    task automatic send_alloc(input logic [SIZE_W-1:0] size);
        req_t item;
        item.operation       = OP_ALLOC;
        item.request_size    = size;
        item.release_address = $urandom();
        send_request(item);
    endtask

    task automatic send_free(input logic [ADDR_W-1:0] addr);
        req_t item;
        item.operation       = OP_FREE;
        item.request_size    = $urandom();
        item.release_address = addr;
        send_request(item);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (ledger.pending_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_heap_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_HEAP_START;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_HEAP_END;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        ledger.heap_base  = lo;
        ledger.heap_limit = hi;
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        stall = 0;
        taken = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                ledger.check_grant(m_data);
                taken++;
                if (taken == HOLD_AT)
                    stall = HOLD_CYCLES;
            end
            if (stall == 0 && !(taken >= 250 && taken < 300) && $urandom_range(0, 99) < 20)
                stall = gap_length();
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] tail;
        ledger = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty heap window: every append runs out
        set_heap_window('0, '0);
        send_alloc('0);
        send_alloc(1);
        send_alloc('1);
        send_free('0);
        send_free('1);
        drain();

        set_heap_window('1, '1);
        send_alloc(1);
        send_alloc(32'h7fff_ffff);
        drain();

        // window that holds exactly one byte-sized block
        set_heap_window('0, 32'd33);
        send_alloc(1);
        send_alloc(1);
        send_free(32'd32);
        send_free(32'd32);
        send_free(32'd33);
        send_alloc(2);
        send_alloc(1);
        drain();

        // heap start low enough that a full table of small blocks fits below the end
        set_heap_window($urandom_range(0, 32'h0080_0000), 32'h0100_0000);
        for (int n = 0; n < 200; n++) begin
            sender_quiet = (n >= 100 && n < 140);
            send_request(random_request());
        end
        sender_quiet = 1'b0;
        while (ledger.blk_count < MAX_BLOCKS)
            send_alloc(1);
        send_alloc(32'h100);
        send_free(ledger.blk_start[MAX_BLOCKS - 1]);
        send_alloc(32'h100);
        send_alloc(1);
        drain();

        // heap end just short of the next header: exhaustion wins over a full table
        tail = ledger.blk_start[ledger.blk_count - 1] + ledger.blk_size[ledger.blk_count - 1];
        set_heap_window('1, tail + 31);
        for (int n = 0; n < 100; n++)
            send_request(random_request());
        drain();

        set_heap_window('0, '1);
        for (int n = 0; n < 100; n++) begin
            sender_quiet = (n < 30);
            if (n == 50)
                drain();
            send_request(random_request());
        end
        sender_quiet = 1'b0;
        drain();

        repeat (MAX_BLOCKS + 8) @(posedge aclk);
        if (ledger.errors == 0)
            $display("first_fit_block_allocator: match");
        else
            $display("first_fit_block_allocator: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: first_fit_block_allocator.f
hdl/ffba_pkg.sv
hdl/ffba_engine.sv
hdl/first_fit_block_allocator.sv
tb/first_fit_block_allocator_tb.sv
